/* design/arbb_pkg.sv */
package arbb_pkg;

    // Fixed field widths
    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 31;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [SIZE_W-1:0] U31_MAX = {SIZE_W{1'b1}};

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5
    } t_reg_idx;

    // Transform mode of a request
    localparam logic MODE_POINT = 1'b0;
    localparam logic MODE_RECT  = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] size_w;
        logic signed [DATA_W-1:0] size_h;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_x;
        logic signed [DATA_W-1:0] res_y;
        logic        [SIZE_W-1:0] res_w;
        logic        [SIZE_W-1:0] res_h;
        logic                     saturated;
    } t_out_item;

    // Affine matrix held by the register file
    typedef struct packed {
        logic signed [DATA_W-1:0] coef_xx;
        logic signed [DATA_W-1:0] coef_xy;
        logic signed [DATA_W-1:0] offset_x;
        logic signed [DATA_W-1:0] coef_yx;
        logic signed [DATA_W-1:0] coef_yy;
        logic signed [DATA_W-1:0] offset_y;
    } t_coefs;

    // Control that travels along with a request through the stages
    typedef struct packed {
        logic valid;
        logic mode;
        logic sat;
    } t_ctl;

endpackage

/* design/arbb_cfg_regs.sv */
module arbb_cfg_regs #(
    parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [arbb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [arbb_pkg::DATA_W-1:0]           i_cfg_wdata,
    output arbb_pkg::t_coefs                      o_coefs
);
    import arbb_pkg::*;

    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

    t_coefs r_coefs;

    // Reset to identity, write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '{coef_xx: ONE_FX, coef_yy: ONE_FX, default: '0};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_COEF_XX:  r_coefs.coef_xx  <= i_cfg_wdata;
                REG_COEF_XY:  r_coefs.coef_xy  <= i_cfg_wdata;
                REG_OFFSET_X: r_coefs.offset_x <= i_cfg_wdata;
                REG_COEF_YX:  r_coefs.coef_yx  <= i_cfg_wdata;
                REG_COEF_YY:  r_coefs.coef_yy  <= i_cfg_wdata;
                REG_OFFSET_Y: r_coefs.offset_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

/* design/arbb_mul_stage.sv */
module arbb_mul_stage #(
    parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF,
    parameter int PS_W      = arbb_pkg::PROD_W - FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  arbb_pkg::t_ctl                        i_ctl,
    input  logic signed [arbb_pkg::DATA_W-1:0]    i_x0,
    input  logic signed [arbb_pkg::DATA_W-1:0]    i_x1,
    input  logic signed [arbb_pkg::DATA_W-1:0]    i_y0,
    input  logic signed [arbb_pkg::DATA_W-1:0]    i_y1,
    input  arbb_pkg::t_coefs                      i_coefs,
    output arbb_pkg::t_ctl                        o_ctl,
    output logic signed [PS_W-1:0]                o_ax0,
    output logic signed [PS_W-1:0]                o_ax1,
    output logic signed [PS_W-1:0]                o_by0,
    output logic signed [PS_W-1:0]                o_by1,
    output logic signed [PS_W-1:0]                o_cx0,
    output logic signed [PS_W-1:0]                o_cx1,
    output logic signed [PS_W-1:0]                o_dy0,
    output logic signed [PS_W-1:0]                o_dy1
);
    import arbb_pkg::*;

    t_ctl                  r_ctl;
    logic signed [PS_W-1:0] r_ax0, r_ax1, r_by0, r_by1;
    logic signed [PS_W-1:0] r_cx0, r_cx1, r_dy0, r_dy1;

    // Exact signed product, floored by the fraction bits
    function automatic logic signed [PS_W-1:0] mul_fx(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return PS_W'(p >>> FRAC_BITS);
    endfunction

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Register the eight distinct corner products; each corner coordinate is a sum of two plus an offset
    always_ff @(posedge i_clk) begin
        r_ax0 <= mul_fx(i_coefs.coef_xx, i_x0);
        r_ax1 <= mul_fx(i_coefs.coef_xx, i_x1);
        r_by0 <= mul_fx(i_coefs.coef_xy, i_y0);
        r_by1 <= mul_fx(i_coefs.coef_xy, i_y1);
        r_cx0 <= mul_fx(i_coefs.coef_yx, i_x0);
        r_cx1 <= mul_fx(i_coefs.coef_yx, i_x1);
        r_dy0 <= mul_fx(i_coefs.coef_yy, i_y0);
        r_dy1 <= mul_fx(i_coefs.coef_yy, i_y1);
    end

    assign o_ctl = r_ctl;
    assign o_ax0 = r_ax0;
    assign o_ax1 = r_ax1;
    assign o_by0 = r_by0;
    assign o_by1 = r_by1;
    assign o_cx0 = r_cx0;
    assign o_cx1 = r_cx1;
    assign o_dy0 = r_dy0;
    assign o_dy1 = r_dy1;

endmodule

/* design/arbb_box_stage.sv */
module arbb_box_stage #(
    parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF,
    parameter int PS_W      = arbb_pkg::PROD_W - FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  arbb_pkg::t_ctl                        i_ctl,
    input  logic signed [PS_W-1:0]                i_ax0,
    input  logic signed [PS_W-1:0]                i_ax1,
    input  logic signed [PS_W-1:0]                i_by0,
    input  logic signed [PS_W-1:0]                i_by1,
    input  logic signed [PS_W-1:0]                i_cx0,
    input  logic signed [PS_W-1:0]                i_cx1,
    input  logic signed [PS_W-1:0]                i_dy0,
    input  logic signed [PS_W-1:0]                i_dy1,
    input  arbb_pkg::t_coefs                      i_coefs,
    output logic                                  o_strobe,
    output arbb_pkg::t_out_item                   o_res
);
    import arbb_pkg::*;

    localparam int SUM_W = PS_W + 2;

    // Stage one: box edges before clipping
    t_ctl                    r_ctl;
    logic signed [SUM_W-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic signed [SUM_W-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [PS_W-1:0]  w_min_a, w_max_a, w_min_b, w_max_b;
    logic signed [PS_W-1:0]  w_min_c, w_max_c, w_min_d, w_max_d;

    // Stage two: clipped result
    logic                    r_strobe;
    t_out_item               r_res;
    t_out_item               n_res;
    logic signed [SUM_W-1:0] w_dw, w_dh;
    logic                    w_sat_x, w_sat_y, w_sat_w, w_sat_h;

    function automatic logic is_ovf32(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[DATA_W-1]}};
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [DATA_W-1:0] res;
        if (!is_ovf32(v)) begin
            res = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = S32_MIN;
        end else begin
            res = S32_MAX;
        end
        return res;
    endfunction

    // Take min and max per term; point mode uses the first corner only
    always_comb begin
        w_min_a = (i_ax1 < i_ax0) ? i_ax1 : i_ax0;
        w_max_a = (i_ax1 > i_ax0) ? i_ax1 : i_ax0;
        w_min_b = (i_by1 < i_by0) ? i_by1 : i_by0;
        w_max_b = (i_by1 > i_by0) ? i_by1 : i_by0;
        w_min_c = (i_cx1 < i_cx0) ? i_cx1 : i_cx0;
        w_max_c = (i_cx1 > i_cx0) ? i_cx1 : i_cx0;
        w_min_d = (i_dy1 < i_dy0) ? i_dy1 : i_dy0;
        w_max_d = (i_dy1 > i_dy0) ? i_dy1 : i_dy0;
        if (i_ctl.mode == MODE_RECT) begin
            n_lo_x = SUM_W'(w_min_a) + SUM_W'(w_min_b) + SUM_W'(i_coefs.offset_x);
            n_hi_x = SUM_W'(w_max_a) + SUM_W'(w_max_b) + SUM_W'(i_coefs.offset_x);
            n_lo_y = SUM_W'(w_min_c) + SUM_W'(w_min_d) + SUM_W'(i_coefs.offset_y);
            n_hi_y = SUM_W'(w_max_c) + SUM_W'(w_max_d) + SUM_W'(i_coefs.offset_y);
        end else begin
            n_lo_x = SUM_W'(i_ax0) + SUM_W'(i_by0) + SUM_W'(i_coefs.offset_x);
            n_lo_y = SUM_W'(i_cx0) + SUM_W'(i_dy0) + SUM_W'(i_coefs.offset_y);
            n_hi_x = n_lo_x;
            n_hi_y = n_lo_y;
        end
    end

    // Hold the box edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_x <= n_lo_x;
        r_hi_x <= n_hi_x;
        r_lo_y <= n_lo_y;
        r_hi_y <= n_hi_y;
    end

    // Clip the low edges to 32 bits and sizes to 31 bits; flag any clipping
    always_comb begin
        w_dw    = r_hi_x - r_lo_x;
        w_dh    = r_hi_y - r_lo_y;
        w_sat_x = is_ovf32(r_lo_x);
        w_sat_y = is_ovf32(r_lo_y);
        w_sat_w = w_dw[SUM_W-1:SIZE_W] != '0;
        w_sat_h = w_dh[SUM_W-1:SIZE_W] != '0;
        n_res.res_x     = sat32(r_lo_x);
        n_res.res_y     = sat32(r_lo_y);
        n_res.res_w     = w_sat_w ? U31_MAX : w_dw[SIZE_W-1:0];
        n_res.res_h     = w_sat_h ? U31_MAX : w_dh[SIZE_W-1:0];
        n_res.saturated = r_ctl.sat | w_sat_x | w_sat_y | w_sat_w | w_sat_h;
    end

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* design/affine_rect_bounding_box_core.sv */
// Affine transform with bounding-box mode. A request is taken whenever start is
// high; busy never rises, so one request may enter on every clock. Each request
// gives exactly one result after the capture, product, box-edge and result
// registers, shown for one cycle with o_strobe; the receiver cannot stall and
// must take it then. The rate of one per cycle is set by the product stage,
// where eight 32x32 multipliers work in parallel on the two x and two y corner
// coordinates. Write the matrix registers only while no request is in flight.
module affine_rect_bounding_box_core #(
    parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  arbb_pkg::t_in_item                    i_req,
    output logic                                  o_strobe,
    output arbb_pkg::t_out_item                   o_res,
    input  logic                                  i_cfg_wr_en,
    input  logic [arbb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [arbb_pkg::DATA_W-1:0]           i_cfg_wdata
);
    import arbb_pkg::*;

    localparam int PS_W = PROD_W - FRAC_BITS;

    t_coefs                   w_coefs;
    t_ctl                     r_a_ctl, n_a_ctl;
    logic signed [DATA_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic signed [DATA_W-1:0] n_x1, n_y1;
    logic signed [DATA_W:0]   w_sum_x, w_sum_y;
    logic                     w_ovf_x, w_ovf_y;
    logic                     w_accept;

    t_ctl                   w_b_ctl;
    logic signed [PS_W-1:0] w_ax0, w_ax1, w_by0, w_by1;
    logic signed [PS_W-1:0] w_cx0, w_cx1, w_dy0, w_dy1;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    arbb_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coefs     (w_coefs)
    );

    // Form the far corner and clip it to 32 bits
    always_comb begin
        w_sum_x = (DATA_W+1)'(i_req.pos_x) + (DATA_W+1)'(i_req.size_w);
        w_sum_y = (DATA_W+1)'(i_req.pos_y) + (DATA_W+1)'(i_req.size_h);
        w_ovf_x = w_sum_x[DATA_W] ^ w_sum_x[DATA_W-1];
        w_ovf_y = w_sum_y[DATA_W] ^ w_sum_y[DATA_W-1];
        if (!w_ovf_x) begin
            n_x1 = w_sum_x[DATA_W-1:0];
        end else begin
            n_x1 = w_sum_x[DATA_W] ? S32_MIN : S32_MAX;
        end
        if (!w_ovf_y) begin
            n_y1 = w_sum_y[DATA_W-1:0];
        end else begin
            n_y1 = w_sum_y[DATA_W] ? S32_MIN : S32_MAX;
        end
        n_a_ctl.valid = w_accept;
        n_a_ctl.mode  = i_req.mode;
        n_a_ctl.sat   = (i_req.mode == MODE_RECT) & (w_ovf_x | w_ovf_y);
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0 <= i_req.pos_x;
        r_y0 <= i_req.pos_y;
        r_x1 <= n_x1;
        r_y1 <= n_y1;
    end

    arbb_mul_stage #(
        .FRAC_BITS (FRAC_BITS),
        .PS_W      (PS_W)
    ) u_mul_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_a_ctl),
        .i_x0    (r_x0),
        .i_x1    (r_x1),
        .i_y0    (r_y0),
        .i_y1    (r_y1),
        .i_coefs (w_coefs),
        .o_ctl   (w_b_ctl),
        .o_ax0   (w_ax0),
        .o_ax1   (w_ax1),
        .o_by0   (w_by0),
        .o_by1   (w_by1),
        .o_cx0   (w_cx0),
        .o_cx1   (w_cx1),
        .o_dy0   (w_dy0),
        .o_dy1   (w_dy1)
    );

    arbb_box_stage #(
        .FRAC_BITS (FRAC_BITS),
        .PS_W      (PS_W)
    ) u_box_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_b_ctl),
        .i_ax0    (w_ax0),
        .i_ax1    (w_ax1),
        .i_by0    (w_by0),
        .i_by1    (w_by1),
        .i_cx0    (w_cx0),
        .i_cx1    (w_cx1),
        .i_dy0    (w_dy0),
        .i_dy1    (w_dy1),
        .i_coefs  (w_coefs),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Every accepted request gives its result on o_strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result missing four cycles after request");

    // No result without an earlier accepted request
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result without request");

    // Point requests give an empty box
    a_point_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_req.mode == MODE_POINT, 4))
            |-> (o_res.res_w == '0 && o_res.res_h == '0))
        else $error("nonzero size on point result");

endmodule
